FILE: rtl/bcb_pkg.sv
`timescale 1ns / 1ps
package bcb_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int WORD_W     = 32;
   localparam int BIT_W      = 5;
   localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int WADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int IDX_W      = WADDR_W + BIT_W;

   localparam int COUNT_W = 11;
   localparam int FIRST_W = 16;
   localparam int LEN_W   = 11;
   localparam int SUM_W   = FIRST_W + 1;

   localparam logic [1:0] CMD_FIND  = 2'd0;
   localparam logic [1:0] CMD_CHECK = 2'd1;
   localparam logic [1:0] CMD_CLAIM = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic [FIRST_W-1:0] first_block;
      logic [LEN_W-1:0]   run_length;
   } req_type;

   typedef struct packed {
      logic               success;
      logic [COUNT_W-1:0] free_block;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic rd_en;
      logic eval;
      logic out_load;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic skip;
      logic scan_done;
      logic out_free;
   } ctl_sts_type;

   // position of the single set bit of a one-hot word
   function automatic logic [BIT_W-1:0] onehot_index(input logic [WORD_W-1:0] oh);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (oh[i]) idx = idx | BIT_W'(i);
      end
      return idx;
   endfunction

endpackage

FILE: rtl/bcb_ctrl.sv
`timescale 1ns / 1ps
module bcb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bcb_pkg::ctl_sts_type sts,
   output bcb_pkg::ctl_cmd_type cmd
);
   import bcb_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_EVAL   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.skip ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.scan_done ? ST_FINISH : ST_READ;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("controller stayed idle after a transfer");
`endif

endmodule

FILE: rtl/bcb_datapath.sv
`timescale 1ns / 1ps
module bcb_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  bcb_pkg::req_type      req_data,
   input  logic                  csr_wr_en,
   input  logic [10:0]           csr_wr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bcb_pkg::rsp_type      rsp_data,
   input  bcb_pkg::ctl_cmd_type  cmd,
   output bcb_pkg::ctl_sts_type  sts
);
   import bcb_pkg::*;

   logic [WORD_W-1:0]  map_mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] row_valid_ff;
   logic [WORD_W-1:0]  rd_data_ff;
   logic               rd_valid_ff;

   logic [COUNT_W-1:0] block_count_ff;
   logic [1:0]         cmd_ff;
   logic [IDX_W-1:0]   start_ff, end_ff;
   logic [WADDR_W-1:0] word_ff;
   logic               ok_ff;
   logic [COUNT_W-1:0] free_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   // status toward the controller
   logic               skip_req;
   logic               scan_done;
   logic               out_free;

   // item decode
   logic [COUNT_W-1:0] n_used;
   logic [SUM_W-1:0]   run_last;
   logic               in_range;
   logic               run_cmd;

   always_comb begin
      n_used   = (SUM_W'(block_count_ff) > SUM_W'(MAX_BLOCKS)) ?
                 COUNT_W'(MAX_BLOCKS) : block_count_ff;
      run_last = SUM_W'(req_data.first_block) + SUM_W'(req_data.run_length) - SUM_W'(1);
      in_range = (req_data.first_block != '0) && (req_data.run_length != '0) &&
                 (run_last <= SUM_W'(n_used));
      run_cmd  = (req_data.command == CMD_CHECK) || (req_data.command == CMD_CLAIM);
      case (req_data.command)
         CMD_FIND:  skip_req = (n_used == '0);
         CMD_CHECK: skip_req = !in_range;
         CMD_CLAIM: skip_req = !in_range;
         default:   skip_req = 1'b1;
      endcase
   end

   // word evaluation
   logic [WORD_W-1:0] word_data, mask, used, free_bits, hit_used, hit_free, wr_data;
   logic [BIT_W-1:0]  lo_bit, hi_bit;
   logic              last_word;
   logic [IDX_W:0]    found_num;

   always_comb begin
      word_data = rd_valid_ff ? rd_data_ff : '0;
      lo_bit    = (word_ff == start_ff[IDX_W-1:BIT_W]) ? start_ff[BIT_W-1:0] : '0;
      hi_bit    = (word_ff == end_ff[IDX_W-1:BIT_W]) ? end_ff[BIT_W-1:0] : '1;
      last_word = (word_ff == end_ff[IDX_W-1:BIT_W]);
      mask      = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_bit));
      used      = word_data & mask;
      free_bits = ~word_data & mask;
      // isolate the lowest set bit
      hit_used  = used & (~used + WORD_W'(1));
      hit_free  = free_bits & (~free_bits + WORD_W'(1));
      // a claim keeps only the bits below the first conflict
      wr_data   = word_data | ((used == '0) ? mask : (mask & (hit_used - WORD_W'(1))));
      found_num = {1'b0, word_ff, onehot_index(hit_free)} + (IDX_W + 1)'(1);
      case (cmd_ff)
         CMD_FIND:  scan_done = (free_bits != '0) || last_word;
         CMD_CHECK: scan_done = (used != '0) || last_word;
         CMD_CLAIM: scan_done = (used != '0) || last_word;
         default:   scan_done = 1'b1;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign sts = '{skip: skip_req, scan_done: scan_done, out_free: out_free};

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= map_mem[word_ff];
      end
      if (cmd.eval && (cmd_ff == CMD_CLAIM)) begin
         map_mem[word_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.eval && (cmd_ff == CMD_CLAIM)) begin
         row_valid_ff[word_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_valid_ff <= row_valid_ff[word_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= '0;
      end else if (csr_wr_en) begin
         block_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_data.command;
         ok_ff   <= run_cmd && in_range;
         free_ff <= '0;
         if (req_data.command == CMD_FIND) begin
            start_ff <= '0;
            end_ff   <= IDX_W'(n_used - COUNT_W'(1));
            word_ff  <= '0;
         end else begin
            start_ff <= IDX_W'(req_data.first_block - FIRST_W'(1));
            end_ff   <= IDX_W'(run_last - SUM_W'(1));
            word_ff  <= WADDR_W'((req_data.first_block - FIRST_W'(1)) >> BIT_W);
         end
      end else if (cmd.eval) begin
         word_ff <= word_ff + WADDR_W'(1);
         if ((cmd_ff == CMD_FIND) && (free_bits != '0)) begin
            ok_ff   <= 1'b1;
            free_ff <= COUNT_W'(found_num);
         end else if (((cmd_ff == CMD_CHECK) || (cmd_ff == CMD_CLAIM)) && (used != '0)) begin
            ok_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.success    <= ok_ff;
         rsp_data_ff.free_block <= free_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");
   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.eval |-> $past(cmd.rd_en))
      else $error("word evaluated without a read");
   a_free_only_find: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.free_block != '0)) |-> rsp_data_ff.success)
      else $error("free block reported without success");
`endif

endmodule

FILE: rtl/block_claim_bitmap.sv
`timescale 1ns / 1ps
// first-fit block allocator over a claimed-bit map of MAX_BLOCKS blocks
// request channel (req_valid/req_ready, req_data): command, first_block, run_length
//   find first free, check that a run is free, or claim a run
// response channel (rsp_valid/rsp_ready, rsp_data): success and free_block,
//   one response per request
// csr_wr_en/csr_wr_data set the number of blocks in use; write only while idle
// the map is held as 32-bit words in a memory; each word visited is read in
// ST_READ and then evaluated in ST_EVAL, and the response is loaded in ST_FINISH;
// out-of-range runs, unused commands and finds with no blocks in use skip the
// scan and go from ST_IDLE straight to ST_FINISH. one request is worked on at a time
// reset clears the map (per-word valid flags), the block count and the response
// a finished response sits in an output register; a new request is accepted while
// it waits, but the next one is not retired until the receiver takes the first
module block_claim_bitmap (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bcb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bcb_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [10:0]      csr_wr_data
);
   import bcb_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   bcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bcb_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import bcb_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [10:0] csr_wr_data = '0;

   block_claim_bitmap u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // allocator state as the testbench sees it
   bit claimed [0:MAX_BLOCKS-1];
   logic [10:0] blocks_cfg = '0;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int errors = 0;
   int cycle_count = 0;
   bit calm = 1'b0;
   bit req_taken = 1'b0;
   int req_gap = 0;
   int rsp_hold = 0;

   function automatic int blocks_live();
      return (int'(blocks_cfg) > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_cfg);
   endfunction

   // 1-based lowest free block in use, 0 when all are claimed
   function automatic int lowest_free();
      int n;
      n = blocks_live();
      for (int i = 0; i < n; i++) begin
         if (!claimed[i]) return i + 1;
      end
      return 0;
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type res;
      int first;
      int len;
      res = '0;
      first = int'(r.first_block);
      len = int'(r.run_length);
      case (r.command)
         CMD_FIND: begin
            res.free_block = COUNT_W'(lowest_free());
            res.success = (res.free_block != 0);
         end
         CMD_CHECK, CMD_CLAIM: begin
            if (first >= 1 && len >= 1 && first + len - 1 <= blocks_live()) begin
               res.success = 1'b1;
               // a claim keeps what it marked before hitting a claimed block
               for (int i = 0; i < len; i++) begin
                  if (claimed[first - 1 + i]) begin
                     res.success = 1'b0;
                     break;
                  end
                  if (r.command == CMD_CLAIM) claimed[first - 1 + i] = 1'b1;
               end
            end
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type random_request();
      req_type r;
      int eff;
      int pick;
      int lo;
      int first;
      int span;
      eff = blocks_live();
      r.first_block = FIRST_W'($urandom);
      r.run_length = LEN_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 25) r.command = CMD_FIND;
      else if (pick < 55) r.command = CMD_CHECK;
      else if (pick < 95) r.command = CMD_CLAIM;
      else r.command = CMD_UNUSED;
      if ((r.command == CMD_CHECK || r.command == CMD_CLAIM) && eff > 0
          && $urandom_range(0, 99) < 85) begin
         lo = lowest_free();
         if (lo != 0 && $urandom_range(0, 1) == 0) first = lo + $urandom_range(0, 3);
         else first = $urandom_range(1, eff);
         if (first > eff) first = eff;
         span = eff - first + 1;
         case ($urandom_range(0, 9))
            0: r.run_length = LEN_W'(span);
            1: r.run_length = LEN_W'(span + 1);
            2, 3: r.run_length = LEN_W'($urandom_range(1, (span < 64) ? span : 64));
            default: r.run_length = LEN_W'($urandom_range(1, (span < 6) ? span : 6));
         endcase
         r.first_block = FIRST_W'(first);
      end
      return r;
   endfunction

   task automatic push_req(logic [1:0] cmd, int first, int len);
      req_type r;
      r.command = cmd;
      r.first_block = FIRST_W'(first);
      r.run_length = LEN_W'(len);
      pending_reqs.push_back(r);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_block_count(logic [10:0] value);
      wait_idle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      blocks_cfg = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(logic [10:0] count, int n);
      int made;
      made = 0;
      write_block_count(count);
      calm = ($urandom_range(0, 3) == 0);
      // feed a couple at a time so the first-fit bias tracks the map
      while (made < n) begin
         if (pending_reqs.size() < 2) begin
            pending_reqs.push_back(random_request());
            made++;
         end else begin
            @(negedge clock);
         end
      end
   endtask

   // driver: inputs move on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold = pick_gap();
      end
   end

   // monitor: check responses before predicting the transfer of the same edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response transfer with no request outstanding");
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.success !== want.success) begin
                  $error("success: expected %0d, actual %0d", want.success, rsp_data.success);
                  errors++;
               end
               if (rsp_data.free_block !== want.free_block) begin
                  $error("free_block: expected %0d, actual %0d",
                         want.free_block, rsp_data.free_block);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) expected_rsps.push_back(apply_request(req_data));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing in use: everything fails
      write_block_count(11'd0);
      push_req(CMD_FIND, 1, 1);
      push_req(CMD_CHECK, 1, 1);
      push_req(CMD_CLAIM, 1, 1);
      push_req(CMD_UNUSED, 1, 1);

      write_block_count(11'd16);
      push_req(CMD_FIND, 0, 0);
      push_req(CMD_CHECK, 0, 1);
      push_req(CMD_CHECK, 1, 0);
      push_req(CMD_CHECK, 16, 1);
      push_req(CMD_CHECK, 16, 2);
      push_req(CMD_CLAIM, 1, 4);
      push_req(CMD_FIND, 0, 0);
      push_req(CMD_CLAIM, 8, 2);
      push_req(CMD_CLAIM, 6, 4);
      push_req(CMD_CHECK, 6, 1);
      push_req(CMD_CLAIM, 5, 1);
      push_req(CMD_FIND, 0, 0);
      push_req(CMD_CLAIM, 10, 7);
      push_req(CMD_CLAIM, 9, 1);
      push_req(CMD_FIND, 0, 0);
      push_req(CMD_UNUSED, 16'hFFFF, 11'h7FF);
      push_req(CMD_CHECK, 16'hFFFF, 11'h7FF);

      // count above capacity acts as the full map
      write_block_count(11'h7FF);
      push_req(CMD_FIND, 0, 0);
      push_req(CMD_CLAIM, 1000, 25);
      push_req(CMD_CHECK, 1024, 1);
      push_req(CMD_CLAIM, 1025, 1);
      push_req(CMD_CHECK, 17, 1008);
      push_req(CMD_FIND, 0, 0);

      random_phase(11'd1, 70);
      random_phase(11'd9, 70);
      random_phase(11'd40, 70);
      random_phase(11'h7FF, 70);
      random_phase(11'd128, 70);
      random_phase(11'd1024, 70);
      random_phase(11'd600, 70);
      random_phase(11'd1023, 70);
      random_phase(11'h7FF, 70);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d responses never arrived", expected_rsps.size());
         errors++;
      end
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
